>>> hw/rtl/aes_pkg.sv
// Package for the AES-128 block encryption core.
// Holds the S-box, round helpers, command codes and the control struct.
`default_nettype none
package aes_pkg;
    localparam int ROUNDS     = 10;
    localparam int KEY_WORDS  = 2 * (ROUNDS + 1);
    localparam int KADDR_W    = $clog2(KEY_WORDS);
    localparam int RCNT_W     = $clog2(ROUNDS + 1);

    localparam logic CMD_LOAD    = 1'b0;
    localparam logic CMD_ENCRYPT = 1'b1;

    typedef struct packed {
        logic                start;   // load plaintext, xor round key 0
        logic                round;   // run one cipher round
        logic                last;    // final round, no MixColumns
        logic [RCNT_W-1:0]   key_sel; // round key to apply
        logic                kwr;     // write one key half
        logic [KADDR_W-1:0]  kaddr;   // key half address for the write
    } t_ctl;

    function automatic logic [7:0] sbox(input logic [7:0] x);
        logic [7:0] t [256];
        t = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
        return t[x];
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    // Byte n of the state sits at bits 127-8n..120-8n.
    function automatic logic [127:0] round_fn(input logic [127:0] s, input logic last);
        logic [7:0] b [16];
        logic [7:0] t [16];
        logic [7:0] a0, a1, a2, a3, al;
        logic [127:0] o;
        for (int n = 0; n < 16; n++) b[n] = s[127-8*n -: 8];
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
                t[r+4*c] = sbox(b[r + 4*((c+r) & 3)]);
        if (!last) begin
            for (int c = 0; c < 4; c++) begin
                a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
                al = a0 ^ a1 ^ a2 ^ a3;
                t[4*c]   = a0 ^ al ^ xtime(a0 ^ a1);
                t[4*c+1] = a1 ^ al ^ xtime(a1 ^ a2);
                t[4*c+2] = a2 ^ al ^ xtime(a2 ^ a3);
                t[4*c+3] = a3 ^ al ^ xtime(a3 ^ a0);
            end
        end
        for (int n = 0; n < 16; n++) o[127-8*n -: 8] = t[n];
        return o;
    endfunction
endpackage
`default_nettype wire

>>> hw/rtl/aes_if.sv
// Valid/ready channel interfaces for the AES core.
// Uses no package.
`default_nettype none
interface aes_in_if;
    logic        valid;
    logic        ready;
    logic        cmd;
    logic [3:0]  key_index;
    logic        key_half;
    logic [63:0] block_hi;
    logic [63:0] block_lo;
    modport source (output valid, cmd, key_index, key_half, block_hi, block_lo, input ready);
    modport sink   (input valid, cmd, key_index, key_half, block_hi, block_lo, output ready);
endinterface

interface aes_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] cipher_hi;
    logic [63:0] cipher_lo;
    modport source (output valid, cipher_hi, cipher_lo, input ready);
    modport sink   (input valid, cipher_hi, cipher_lo, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/aes_ctrl.sv
// Sequencer for the AES core: accepts words and steps the rounds.
// Depends on aes_pkg.
`default_nettype none
module aes_ctrl (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    input  wire logic                  i_cmd,
    input  wire logic [3:0]            i_key_index,
    input  wire logic                  i_key_half,
    output logic                       o_ready,
    input  wire logic                  i_out_busy,
    output logic                       o_done,
    output aes_pkg::t_ctl              o_ctl
);
    typedef enum logic {S_IDLE, S_RUN} t_state;
    t_state r_state, n_state;
    logic [aes_pkg::RCNT_W-1:0] r_rnd, n_rnd;
    logic acc;

    // A new word waits until the previous result has left the output stage.
    assign o_ready = (r_state == S_IDLE) && !i_out_busy;
    assign acc     = i_valid && o_ready;

    always_comb begin
        n_state = r_state;
        n_rnd   = r_rnd;
        o_ctl   = '0;
        o_done  = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (acc && i_cmd == aes_pkg::CMD_ENCRYPT) begin
                    o_ctl.start = 1'b1;
                    n_rnd   = aes_pkg::RCNT_W'(1);
                    n_state = S_RUN;
                end else if (acc && i_key_index <= 4'(aes_pkg::ROUNDS)) begin
                    o_ctl.kwr   = 1'b1;
                    o_ctl.kaddr = aes_pkg::KADDR_W'({i_key_index, i_key_half});
                end
            end
            S_RUN: begin
                o_ctl.round   = 1'b1;
                o_ctl.key_sel = r_rnd;
                o_ctl.last    = (r_rnd == aes_pkg::RCNT_W'(aes_pkg::ROUNDS));
                n_rnd = r_rnd + 1'b1;
                if (o_ctl.last) begin
                    o_done  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_rnd   <= '0;
        end else begin
            r_state <= n_state;
            r_rnd   <= n_rnd;
        end
    end
endmodule
`default_nettype wire

>>> hw/rtl/aes_dp.sv
// Datapath for the AES core: key store, state register, round logic.
// Depends on aes_pkg.
`default_nettype none
module aes_dp (
    input  wire logic          i_clk,
    input  wire aes_pkg::t_ctl i_ctl,
    input  wire logic [63:0]   i_hi,
    input  wire logic [63:0]   i_lo,
    output logic [127:0]       o_state
);
    logic [63:0]  r_key [aes_pkg::KEY_WORDS];
    logic [127:0] r_state;
    logic [127:0] rkey;

    // Key halves are read at one round index per cycle.
    assign rkey = {r_key[aes_pkg::KADDR_W'({i_ctl.key_sel, 1'b0})],
                   r_key[aes_pkg::KADDR_W'({i_ctl.key_sel, 1'b1})]};

    always_ff @(posedge i_clk) begin
        if (i_ctl.kwr) r_key[i_ctl.kaddr] <= i_hi;
        if (i_ctl.start)
            r_state <= {i_hi, i_lo} ^ rkey;
        else if (i_ctl.round)
            r_state <= aes_pkg::round_fn(r_state, i_ctl.last) ^ rkey;
    end

    assign o_state = r_state;
endmodule
`default_nettype wire

>>> hw/rtl/aes128_block_encrypt_top.sv
// Top level of the AES-128 block encryption core.
// Depends on aes_pkg, aes_if, aes_ctrl and aes_dp.
`default_nettype none
// This core encrypts 128-bit blocks with AES-128 using round keys that the
// user loads beforehand: a word with cmd 0 writes one 64-bit half of round
// key key_index (half 0 is key bytes 0 to 7, taken from block_hi), and loads
// with an index above ten are dropped. Every round key half must be written
// before the first encryption. A word with cmd 1 encrypts {block_hi,
// block_lo} in FIPS-197 byte order. An encryption does the initial key
// addition and then the ten rounds in turn through a single shared round
// unit, with the result registered at the end. A new word is accepted once
// the core is idle and the output stage is free.
module aes128_block_encrypt_top (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    aes_in_if.sink     in_ch,
    aes_out_if.source  out_ch
);
    aes_pkg::t_ctl ctl;
    logic          done;
    logic [127:0]  state;
    logic          r_ovalid;

    aes_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(in_ch.valid), .i_cmd(in_ch.cmd),
        .i_key_index(in_ch.key_index), .i_key_half(in_ch.key_half),
        .o_ready(in_ch.ready), .i_out_busy(r_ovalid),
        .o_done(done), .o_ctl(ctl)
    );

    aes_dp u_dp (
        .i_clk(i_clk), .i_ctl(ctl),
        .i_hi(in_ch.block_hi), .i_lo(in_ch.block_lo),
        .o_state(state)
    );

    // The state register holds the ciphertext until the sink takes it,
    // since no new encryption starts while the result is pending.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (done) begin
            r_ovalid <= 1'b1;
        end else if (out_ch.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    assign out_ch.valid     = r_ovalid;
    assign out_ch.cipher_hi = state[127:64];
    assign out_ch.cipher_lo = state[63:0];
endmodule
`default_nettype wire

>>> tb/aes128_block_encrypt_tb_if.sv
// Note: the channel interfaces come from the RTL (aes_if.sv); this file only
// holds the word type the testbench queues. Depends on nothing else.
`default_nettype none
package aes_tb_pkg;
    typedef struct {
        logic        cmd;
        logic [3:0]  key_index;
        logic        key_half;
        logic [63:0] block_hi;
        logic [63:0] block_lo;
        logic        has_exp;    // typed-in expectation present
        logic [63:0] exp_hi;
        logic [63:0] exp_lo;
    } t_word;
endpackage
`default_nettype wire

>>> tb/aes128_block_encrypt_top_tb.sv
// Testbench for aes128_block_encrypt_top: drives load and encrypt words,
// predicts each ciphertext with its own AES-128 model and checks the output.
// Depends on aes_pkg, aes_if, aes_tb_pkg and the RTL.
`default_nettype none
module aes128_block_encrypt_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_CYCLES = 200000;   // watchdog: cycles with no accepted word

    logic i_clk;
    logic i_rst_n;

    aes_in_if  in_ch();
    aes_out_if out_ch();

    aes128_block_encrypt_top u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Own copy of the round key store; an unwritten half reads as zero.
    logic [63:0] key_mem [aes_pkg::KEY_WORDS];
    logic [127:0] cipher_q [$];        // ciphertexts still to come out
    int  fails = 0;
    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    int  hold_cycles = 0;               // receiver long stall, counted below
    bit  done_sending = 0;
    int  quiet = 0;

    // S-box lookup written out as its own table.
    logic [7:0] sb [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};

    function automatic logic [7:0] gf_double(input logic [7:0] x);
        return (x << 1) ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    // Full AES-128 encryption over the current key store. Byte n of the
    // state is bits 127-8n down to 120-8n, which is FIPS-197 order.
    function automatic logic [127:0] aes128_cipher(input logic [127:0] pt);
        logic [7:0]   s [16];
        logic [7:0]   t [16];
        logic [127:0] rk;
        logic [7:0]   a0, a1, a2, a3, sum;
        for (int n = 0; n < 16; n++) s[n] = pt[127-8*n -: 8];
        for (int r = 0; r <= aes_pkg::ROUNDS; r++) begin
            if (r > 0) begin
                // SubBytes and ShiftRows together: row w rotates left by w.
                for (int c = 0; c < 4; c++)
                    for (int w = 0; w < 4; w++)
                        t[w+4*c] = sb[s[w + 4*((c+w) % 4)]];
                if (r < aes_pkg::ROUNDS) begin
                    for (int c = 0; c < 4; c++) begin
                        a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
                        sum = a0 ^ a1 ^ a2 ^ a3;
                        t[4*c]   = a0 ^ sum ^ gf_double(a0 ^ a1);
                        t[4*c+1] = a1 ^ sum ^ gf_double(a1 ^ a2);
                        t[4*c+2] = a2 ^ sum ^ gf_double(a2 ^ a3);
                        t[4*c+3] = a3 ^ sum ^ gf_double(a3 ^ a0);
                    end
                end
                s = t;
            end
            rk = {key_mem[2*r], key_mem[2*r+1]};
            for (int n = 0; n < 16; n++) s[n] ^= rk[127-8*n -: 8];
        end
        for (int n = 0; n < 16; n++) aes128_cipher[127-8*n -: 8] = s[n];
    endfunction

    // FIPS-197 appendix C.1 key schedule, key 000102..0f.
    logic [127:0] fips_keys [11] = '{
        128'h000102030405060708090a0b0c0d0e0f, 128'hd6aa74fdd2af72fadaa678f1d6ab76fe,
        128'hb692cf0b643dbdf1be9bc5006830b3fe, 128'hb6ff744ed2c2c9bf6c590cbf0469bf41,
        128'h47f7f7bc95353e03f96c32bcfd058dfd, 128'h3caaa3e8a99f9deb50f3af57adf622aa,
        128'h5e390f7df7a69296a7553dc10aa31f6b, 128'h14f9701ae35fe28c440adf4d4ea9c026,
        128'h47438735a41c65b9e016baf4aebf7ad2, 128'h549932d1f08557681093ed9cbe2c974e,
        128'h13111d7fe3944a17f307a78b4d2b30c5};

    function automatic aes_tb_pkg::t_word load_word(input int idx, input bit half,
                                                    input logic [63:0] d);
        aes_tb_pkg::t_word w;
        w = '{aes_pkg::CMD_LOAD, idx[3:0], half, d, 64'($urandom) << 32 | $urandom,
              1'b0, '0, '0};
        return w;
    endfunction

    function automatic aes_tb_pkg::t_word enc_word(input logic [127:0] pt, input bit has,
                                                   input logic [127:0] ct);
        aes_tb_pkg::t_word w;
        w = '{aes_pkg::CMD_ENCRYPT, 4'($urandom), 1'($urandom), pt[127:64], pt[63:0],
              has, ct[127:64], ct[63:0]};
        return w;
    endfunction

    function automatic logic [63:0] rand64();
        return {32'($urandom), 32'($urandom)};
    endfunction

    // Send one word; the expectation is computed at the accepting edge so
    // that key loads and encryptions keep their order. The word stays valid
    // after acceptance until the next word, an idle cycle or a drain.
    task automatic send_word(input aes_tb_pkg::t_word w);
        logic [127:0] ct;
        while (send_idle_pct > 0 && $urandom_range(99, 0) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.cmd       <= w.cmd;
        in_ch.key_index <= w.key_index;
        in_ch.key_half  <= w.key_half;
        in_ch.block_hi  <= w.block_hi;
        in_ch.block_lo  <= w.block_lo;
        do @(posedge i_clk); while (!in_ch.ready);
        if (w.cmd == aes_pkg::CMD_LOAD) begin
            if (w.key_index <= aes_pkg::ROUNDS)
                key_mem[2*w.key_index + w.key_half] = w.block_hi;
        end else begin
            ct = aes128_cipher({w.block_hi, w.block_lo});
            if (w.has_exp && ct !== {w.exp_hi, w.exp_lo}) begin
                $display("%0t predictor disagrees with table: exp %h got %h",
                         $time, {w.exp_hi, w.exp_lo}, ct);
                fails++;
            end
            cipher_q.push_back(ct);
        end
        @(negedge i_clk);
    endtask

    // Drops valid, then waits until every result is out.
    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        do @(negedge i_clk); while (cipher_q.size() != 0);
    endtask

    task automatic load_keys(input logic [127:0] ks [11]);
        for (int k = 0; k <= aes_pkg::ROUNDS; k++) begin
            send_word(load_word(k, 0, ks[k][127:64]));
            send_word(load_word(k, 1, ks[k][63:0]));
        end
    endtask

    // Receiver: random stalls, plus a long hold-off when hold_cycles is set.
    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            hold_cycles  <= hold_cycles - 1;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= !(recv_idle_pct > 0 && $urandom_range(99, 0) < recv_idle_pct);
        end
    end

    // Checker and watchdog, both on the rising edge.
    always @(posedge i_clk) begin
        logic [127:0] want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (cipher_q.size() == 0) begin
                $display("%0t unexpected word: got %h_%h", $time,
                         out_ch.cipher_hi, out_ch.cipher_lo);
                fails++;
            end else begin
                want = cipher_q.pop_front();
                if (out_ch.cipher_hi !== want[127:64]) begin
                    $display("%0t cipher_hi mismatch: exp %h got %h", $time,
                             want[127:64], out_ch.cipher_hi);
                    fails++;
                end
                if (out_ch.cipher_lo !== want[63:0]) begin
                    $display("%0t cipher_lo mismatch: exp %h got %h", $time,
                             want[63:0], out_ch.cipher_lo);
                    fails++;
                end
            end
        end
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
            (done_sending && cipher_q.size() == 0))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet > IDLE_CYCLES) begin
            $display("aes128_block_encrypt_top_tb NOT OK");
            $finish;
        end
    end

    // Directed table: FIPS-197 appendix vectors and extreme blocks. Rows with
    // has_exp set carry a ciphertext read straight off the standard.
    aes_tb_pkg::t_word dir_tab [$];
    logic [127:0] rand_keys [11];

    initial begin
        in_ch.valid = 1'b0; in_ch.cmd = aes_pkg::CMD_LOAD; in_ch.key_index = '0;
        in_ch.key_half = 1'b0; in_ch.block_hi = '0; in_ch.block_lo = '0;
        out_ch.ready = 1'b0;
        for (int i = 0; i < aes_pkg::KEY_WORDS; i++) key_mem[i] = '0;
        i_rst_n = 1'b0;
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Key schedule first, since no encryption may read an unwritten half.
        for (int k = 0; k <= aes_pkg::ROUNDS; k++) begin
            dir_tab.push_back(load_word(k, 0, fips_keys[k][127:64]));
            dir_tab.push_back(load_word(k, 1, fips_keys[k][63:0]));
        end
        // Out-of-range key index: must be dropped and not disturb the store.
        dir_tab.push_back(load_word(11, 0, '1));
        dir_tab.push_back(load_word(15, 1, '1));
        dir_tab.push_back(enc_word(128'h00112233445566778899aabbccddeeff, 1,
                                   128'h69c4e0d86a7b0430d8cdb78070b4c55a));
        dir_tab.push_back(enc_word('0, 0, '0));
        dir_tab.push_back(enc_word('1, 0, '0));
        dir_tab.push_back(enc_word(128'h8000_0000_0000_0000_0000_0000_0000_0001, 0, '0));
        foreach (dir_tab[i]) send_word(dir_tab[i]);
        wait_drained();

        // Pressure: a long receiver hold-off while words keep coming.
        hold_cycles = 300;
        for (int i = 0; i < 6; i++) send_word(enc_word({rand64(), rand64()}, 0, '0));
        wait_drained();

        // Random phases, each with its own idle mix.
        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct = (ph == 0) ? 26 : (ph == 1) ? 46 : 0;
            recv_idle_pct = (ph == 0) ? 46 : (ph == 1) ? 26 : 0;
            // Wait for the pipe to empty, then rekey with random round keys.
            wait_drained();
            for (int k = 0; k <= aes_pkg::ROUNDS; k++) rand_keys[k] = {rand64(), rand64()};
            if (ph == 2) rand_keys[aes_pkg::ROUNDS] = '1;
            load_keys(rand_keys);
            for (int i = 0; i < 160; i++) begin
                case ($urandom_range(9, 0))
                    0: send_word(load_word($urandom_range(15, 0), 1'($urandom), rand64()));
                    default: send_word(enc_word({rand64(), rand64()}, 0, '0));
                endcase
                if (i == 80) wait_drained();   // sender pauses until drained
            end
        end
        done_sending = 1;
        wait_drained();
        repeat (30) @(negedge i_clk);

        if (fails == 0 && cipher_q.size() == 0)
            $display("aes128_block_encrypt_top_tb OK");
        else
            $display("aes128_block_encrypt_top_tb NOT OK");
        $finish;
    end
endmodule
`default_nettype wire

>>> files.f
hw/rtl/aes_pkg.sv
hw/rtl/aes_if.sv
hw/rtl/aes_ctrl.sv
hw/rtl/aes_dp.sv
hw/rtl/aes128_block_encrypt_top.sv
tb/aes128_block_encrypt_tb_if.sv
tb/aes128_block_encrypt_top_tb.sv
